// ===== rtl/core/sss_pkg.sv =====
// ----------------------------------------------------------------------------
// sss_pkg
// Shared constants and types for the stock span stack.
// ----------------------------------------------------------------------------
package sss_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int PRICE_WIDTH = 32;
    localparam int DAY_W       = 32;
    localparam int FILL_W      = $clog2(STACK_DEPTH) + 1;

    localparam logic [DAY_W-1:0] DAY_MAX = {DAY_W{1'b1}};

    typedef struct packed {
        logic signed [PRICE_WIDTH-1:0] price;
        logic [DAY_W-1:0]              day;
    } entry_t;

    typedef struct packed {
        logic push;
        logic pop;
    } shift_t;

endpackage

// ===== rtl/core/sss_cell.sv =====
// ----------------------------------------------------------------------------
// sss_cell
// One stack slot. Push takes the entry from the slot above, pop from below.
// ----------------------------------------------------------------------------
module sss_cell (
    input  logic            clk,
    input  sss_pkg::shift_t shift,
    input  sss_pkg::entry_t above,
    input  sss_pkg::entry_t below,
    output sss_pkg::entry_t entry
);
    import sss_pkg::*;

    entry_t entry_reg;

    always_ff @(posedge clk)
    begin
        if (shift.push)
        begin
            entry_reg <= above;
        end
        else if (shift.pop)
        begin
            entry_reg <= below;
        end
    end

    assign entry = entry_reg;

endmodule

// ===== rtl/core/stock_span_monotonic_stack.sv =====
// ----------------------------------------------------------------------------
// stock_span_monotonic_stack
// Stock span over a monotonic stack held in a chain of shift cells.
// ----------------------------------------------------------------------------
// One price per input transfer, one span per output transfer. The stack is a
// row of STACK_DEPTH cells with the top in cell 0; each cycle the whole row
// shifts by one slot at most. An item is accepted, then each top entry whose
// price is not above the new price is popped, then the new entry is pushed;
// each entry is popped at most once after its push. The push waits while an
// earlier span is still stalled in the output register. A full stack drops
// its oldest entry; no clearing pass: only fill, day and overflow are reset.
module stock_span_monotonic_stack (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [sss_pkg::PRICE_WIDTH-1:0] price,
    input  logic                                 start_series,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [sss_pkg::DAY_W-1:0]            span,
    output logic                                 stack_overflow
);
    import sss_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WORK = 2'b10
    } state_t;

    state_t                  state_reg, state_next;
    logic [FILL_W-1:0]       fill_reg, fill_next;
    logic [DAY_W-1:0]        day_reg, day_next;
    logic                    ovf_reg, ovf_next;
    logic signed [PRICE_WIDTH-1:0] key_reg;
    logic                    out_valid_reg, out_valid_next;
    logic [DAY_W-1:0]        span_reg, span_next;
    logic                    out_ovf_reg, out_ovf_next;

    shift_t                  shift;
    entry_t                  cells [STACK_DEPTH];
    entry_t                  new_entry;
    entry_t                  empty_entry;

    logic accept;
    logic top_pop;
    logic slot_free;

    assign accept    = (state_reg == S_IDLE) && in_valid;
    assign top_pop   = (fill_reg != '0) && (cells[0].price <= key_reg);
    assign slot_free = !out_valid_reg || !out_stall;

    assign new_entry.price   = key_reg;
    assign new_entry.day     = day_reg;
    assign empty_entry       = '0;

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        day_next       = day_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg && out_stall;
        span_next      = span_reg;
        out_ovf_next   = out_ovf_reg;
        shift          = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_WORK;
                    if (start_series)
                    begin
                        fill_next = '0;
                        day_next  = '0;
                        ovf_next  = 1'b0;
                    end
                end
            end
            S_WORK:
            begin
                if (top_pop)
                begin
                    shift.pop = 1'b1;
                    fill_next = fill_reg - FILL_W'(1);
                end
                else if (slot_free)
                begin
                    shift.push = 1'b1;
                    if (fill_reg == '0)
                    begin
                        span_next = (day_reg == DAY_MAX) ? DAY_MAX : day_reg + DAY_W'(1);
                    end
                    else
                    begin
                        span_next = day_reg - cells[0].day;
                    end
                    if (fill_reg == FILL_W'(STACK_DEPTH))
                    begin
                        ovf_next     = 1'b1;
                        out_ovf_next = 1'b1;
                    end
                    else
                    begin
                        fill_next    = fill_reg + FILL_W'(1);
                        out_ovf_next = ovf_reg;
                    end
                    if (day_reg != DAY_MAX)
                    begin
                        day_next = day_reg + DAY_W'(1);
                    end
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            day_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            day_reg       <= day_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg <= price;
        end
        span_reg    <= span_next;
        out_ovf_reg <= out_ovf_next;
    end

    genvar i;
    generate
        for (i = 0; i < STACK_DEPTH; i++)
        begin : g_cell
            entry_t above_in;
            entry_t below_in;
            if (i == 0)
            begin : g_top
                assign above_in = new_entry;
            end
            else
            begin : g_mid
                assign above_in = cells[i-1];
            end
            if (i == STACK_DEPTH - 1)
            begin : g_bot
                assign below_in = empty_entry;
            end
            else
            begin : g_up
                assign below_in = cells[i+1];
            end
            sss_cell u_cell (
                .clk   (clk),
                .shift (shift),
                .above (above_in),
                .below (below_in),
                .entry (cells[i])
            );
        end
    endgenerate

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;
    assign span           = span_reg;
    assign stack_overflow = out_ovf_reg;

endmodule

// ===== test/stock_span_monotonic_stack_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stock_span_monotonic_stack_tb
// Self-checking bench for the stock span stack.
// ----------------------------------------------------------------------------
// A queue of prices feeds a clocked driver; a clocked monitor compares each
// span transfer with a span model kept in the bench. Runs pass through idle
// and stall phases, overflow series and equal-price runs.
// ----------------------------------------------------------------------------
module stock_span_monotonic_stack_tb;
    import sss_pkg::*;

    typedef struct {
        logic signed [PRICE_WIDTH-1:0] price;
        logic                          start;
    } day_item_t;

    typedef struct {
        logic [DAY_W-1:0] span;
        logic             ovf;
    } span_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [PRICE_WIDTH-1:0] price = '0;
    logic start_series = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [DAY_W-1:0] span;
    logic stack_overflow;

    day_item_t    pending_days[$];
    span_result_t expected_spans[$];

    logic signed [PRICE_WIDTH-1:0] mdl_prices[STACK_DEPTH];
    logic [DAY_W-1:0]              mdl_days[STACK_DEPTH];
    int                            mdl_fill = 0;
    logic [DAY_W-1:0]              mdl_day = '0;
    logic                          mdl_ovf = 1'b0;

    int  error_count = 0;
    int  idle_pct = 0;
    int  stall_pct = 0;

    stock_span_monotonic_stack u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .price          (price),
        .start_series   (start_series),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .span           (span),
        .stack_overflow (stack_overflow)
    );

    always #4 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [DAY_W-1:0] got,
                                   input logic [DAY_W-1:0] want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic span_result_t predict_span(input day_item_t d);
        span_result_t r;
        logic [DAY_W:0] s;
        if (d.start)
        begin
            mdl_fill = 0;
            mdl_day = '0;
            mdl_ovf = 1'b0;
        end
        while (mdl_fill > 0 && mdl_prices[mdl_fill-1] <= d.price)
            mdl_fill--;
        if (mdl_fill == 0)
            s = {1'b0, mdl_day} + 1;
        else
            s = {1'b0, mdl_day} - {1'b0, mdl_days[mdl_fill-1]};
        if (s > {1'b0, DAY_MAX})
            s = {1'b0, DAY_MAX};
        if (mdl_fill == STACK_DEPTH)
        begin
            for (int i = 0; i < STACK_DEPTH - 1; i++)
            begin
                mdl_prices[i] = mdl_prices[i+1];
                mdl_days[i] = mdl_days[i+1];
            end
            mdl_fill--;
            mdl_ovf = 1'b1;
        end
        mdl_prices[mdl_fill] = d.price;
        mdl_days[mdl_fill] = mdl_day;
        mdl_fill++;
        if (mdl_day != DAY_MAX)
            mdl_day++;
        r.span = s[DAY_W-1:0];
        r.ovf = mdl_ovf;
        return r;
    endfunction

    function automatic logic signed [PRICE_WIDTH-1:0] rand_price();
        case ($urandom_range(0, 5))
            0: return $signed($urandom());
            1: return $signed(32'h8000_0000 + $urandom_range(0, 3));
            2: return $signed(32'h7fff_ffff - $urandom_range(0, 3));
            default: return $signed($urandom_range(0, 40)) - 20;
        endcase
    endfunction

    task automatic add_day(input logic signed [PRICE_WIDTH-1:0] p, input logic s);
        day_item_t d;
        d.price = p;
        d.start = s;
        pending_days = {pending_days, d};
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!(in_valid && in_stall))
        begin
            if (pending_days.size() > 0 && $urandom_range(0, 99) >= idle_pct)
            begin
                day_item_t d;
                d = pending_days.pop_front();
                expected_spans = {expected_spans, predict_span(d)};
                in_valid <= 1'b1;
                price <= d.price;
                start_series <= d.start;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_spans.size() == 0)
                begin
                    $display("unexpected span transfer at %0t", $realtime);
                    error_count++;
                end
                else
                begin
                    span_result_t e;
                    e = expected_spans.pop_front();
                    if (span !== e.span)
                        report_mismatch("span", span, e.span);
                    if (stack_overflow !== e.ovf)
                        report_mismatch("stack_overflow", DAY_W'(stack_overflow),
                                        DAY_W'(e.ovf));
                end
            end
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic drain();
        while (pending_days.size() > 0 || in_valid || expected_spans.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, equal prices, ramps
        add_day(32'sh7fffffff, 1'b0);
        add_day(-32'sh7fffffff - 1, 1'b0);
        add_day(5, 1'b0);
        add_day(5, 1'b0);
        add_day(3, 1'b0);
        add_day(5, 1'b0);
        add_day(-32'sh7fffffff - 1, 1'b0);
        add_day(32'sh7fffffff, 1'b0);
        add_day(32'sh7fffffff, 1'b0);
        add_day(0, 1'b1);
        add_day(-1, 1'b0);
        add_day(1, 1'b0);
        add_day(-32'sh7fffffff - 1, 1'b1);
        for (int i = 0; i < 8; i++)
            add_day(10 - i, 1'b0);
        add_day(20, 1'b0);
        drain();

        // overflow: strictly decreasing series longer than the stack
        add_day(32'sh7fffffff, 1'b1);
        for (int i = 1; i < STACK_DEPTH + 40; i++)
            add_day(32'sh7fffffff - i, 1'b0);
        add_day(32'sh7fffffff, 1'b0);
        add_day(0, 1'b0);
        add_day(1, 1'b1);
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            idle_pct = (phase == 1 || phase == 3) ? 45 : 0;
            stall_pct = (phase == 2 || phase == 3) ? 45 : 0;
            if (phase == 3)
            begin
                idle_pct = 9;
                stall_pct = 9;
            end
            for (int n = 0; n < 80; n++)
                add_day(rand_price(), ($urandom_range(0, 59) == 0));
            drain();
        end
        idle_pct = 0;
        stall_pct = 0;
        repeat (50) @(posedge clk);
        if (error_count == 0 && expected_spans.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

endmodule
